FILE: hdl/bsm3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsm3_pkg: shared types and constants
// Item payload types, request codes and status codes of the stencil engine.
// ----------------------------------------------------------------------------
package bsm3_pkg;

    localparam logic [1:0] REQ_VEC  = 2'd0;
    localparam logic [1:0] REQ_COEF = 2'd1;
    localparam logic [1:0] REQ_CALC = 2'd2;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_BAD = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    // Neighbor codes used by the term sequencer.
    localparam logic [2:0] NB_C  = 3'd0;
    localparam logic [2:0] NB_ZM = 3'd1;
    localparam logic [2:0] NB_ZP = 3'd2;
    localparam logic [2:0] NB_YM = 3'd3;
    localparam logic [2:0] NB_YP = 3'd4;
    localparam logic [2:0] NB_XM = 3'd5;
    localparam logic [2:0] NB_XP = 3'd6;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [4:0]         cell_x;
        logic [4:0]         cell_y;
        logic [4:0]         cell_z;
        logic [1:0]         component;
        logic [3:0]         coef_index;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result_er;
        logic signed [31:0] result_f1;
        logic signed [31:0] result_f2;
        logic signed [31:0] result_f3;
        logic [1:0]         status;
    } t_out;

    // One term of a row: coefficient slot, neighbor and vector component.
    typedef struct packed {
        logic [3:0] slot;
        logic [2:0] nb;
        logic [1:0] cmp;
    } t_term;

    // Term table. Row 0 has 16 terms; rows 1-3 have 14 and use their own
    // component where the table says so.
    function automatic t_term term_of(input logic [1:0] row, input logic [3:0] t);
        t_term r;
        logic [3:0] s0 [16];
        logic [2:0] n0 [16];
        logic [1:0] c0 [16];
        logic [3:0] sn [14];
        logic [2:0] nn [14];
        logic       own [14];
        s0 = '{4'd0, 4'd14, 4'd2, 4'd12, 4'd4, 4'd10, 4'd1, 4'd15,
               4'd3, 4'd13, 4'd5, 4'd11, 4'd6, 4'd7, 4'd8, 4'd9};
        n0 = '{NB_ZM, NB_ZP, NB_YM, NB_YP, NB_XM, NB_XP, NB_ZM, NB_ZP,
               NB_YM, NB_YP, NB_XM, NB_XP, NB_C, NB_C, NB_C, NB_C};
        c0 = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd3, 2'd3,
               2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd1, 2'd2, 2'd3};
        sn = '{4'd0, 4'd12, 4'd2, 4'd10, 4'd4, 4'd8, 4'd1, 4'd13,
               4'd3, 4'd11, 4'd5, 4'd9, 4'd6, 4'd7};
        nn = '{NB_ZM, NB_ZP, NB_YM, NB_YP, NB_XM, NB_XP, NB_ZM, NB_ZP,
               NB_YM, NB_YP, NB_XM, NB_XP, NB_C, NB_C};
        own = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
        if (row == 2'd0) begin
            r.slot = s0[t];
            r.nb   = n0[t];
            r.cmp  = c0[t];
        end else if (t < 4'd14) begin
            r.slot = sn[t];
            r.nb   = nn[t];
            r.cmp  = own[t] ? row : 2'd0;
        end else begin
            r = '0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/block_stencil_matvec_3d_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_stencil_matvec_3d_top: seven-point stencil 4x4 block matrix-vector
// Memory-backed engine: vector and coefficient writes, and one-cell products.
// ----------------------------------------------------------------------------
// Raise start with an item while busy is low; the item is taken at that
// clock edge. Every item gives exactly one result, shown for one cycle with
// o_done high. The receiver cannot stall it, so it must take it then. A write
// or a rejected item passes through the output state and shows its result
// as the engine returns to idle. A compute runs its 58 terms (16 for row 0,
// 14 for each of rows 1-3) one per cycle through the coefficient and vector
// memories (one read port each). Each row then waits in the drain state for
// the memory read, product register and accumulate stages to drain, and
// rounds and stores the row in the finish state. Busy stays high through a
// compute and while the result shows, so no new item is taken before the
// result has shown. The single read port per memory and the single
// multiply-accumulate path set how long a compute takes. Both memories hold
// garbage until written: only read what has been written.
// ----------------------------------------------------------------------------
module block_stencil_matvec_3d_top #(
    parameter int GRID_X    = 16,
    parameter int GRID_Y    = 16,
    parameter int GRID_Z    = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            start,
    output logic           busy,
    input  bsm3_pkg::t_in  i_item,
    output logic           o_done,
    output bsm3_pkg::t_out o_result
);
    import bsm3_pkg::*;

    localparam int SX = GRID_X + 2;
    localparam int SY = GRID_Y + 2;
    localparam int SZ = GRID_Z + 2;
    localparam int VDEPTH = SX * SY * SZ * 4;
    localparam int CDEPTH = GRID_X * GRID_Y * GRID_Z * 64;
    localparam int VAW = $clog2(VDEPTH);
    localparam int CAW = $clog2(CDEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_DRN  = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [31:0] r_vmem [VDEPTH];
    logic [31:0] r_cmem [CDEPTH];

    logic [2:0]  r_state;
    t_in         r_item;
    logic [1:0]  r_row;
    logic [3:0]  r_term;
    logic        r_rdv;
    logic        r_last;
    logic [2:0]  r_drn;
    logic [31:0] r_vq, r_cq;
    logic signed [31:0] r_res [4];
    logic        r_sat;
    logic        r_done;
    t_out        r_out;

    logic        w_vok, w_inner, w_cok;
    logic        w_take;
    logic [VAW-1:0] w_vwaddr, w_vraddr;
    logic [CAW-1:0] w_cwaddr, w_craddr;
    t_term       w_t;
    logic [4:0]  w_nx, w_ny, w_nz;
    logic [CAW-1:0] w_cell;
    logic        w_clear, w_mbusy, w_msat;
    logic signed [31:0] w_mres;
    logic        w_acc;

    function automatic logic [CAW-1:0] cell_of(input logic [4:0] x, input logic [4:0] y,
                                               input logic [4:0] z);
        return CAW'((32'(z) - 1) * GRID_Y * GRID_X + (32'(y) - 1) * GRID_X + (32'(x) - 1));
    endfunction

    // An item is taken only while the engine is idle and no result is showing.
    assign w_take  = start && !busy;

    assign w_vok   = 32'(i_item.cell_x) <= GRID_X + 1 && 32'(i_item.cell_y) <= GRID_Y + 1
                     && 32'(i_item.cell_z) <= GRID_Z + 1;
    assign w_inner = i_item.cell_x != 5'd0 && 32'(i_item.cell_x) <= GRID_X
                     && i_item.cell_y != 5'd0 && 32'(i_item.cell_y) <= GRID_Y
                     && i_item.cell_z != 5'd0 && 32'(i_item.cell_z) <= GRID_Z;
    assign w_cok   = w_inner && (i_item.component == 2'd0 || i_item.coef_index < 4'd14);
    assign w_vwaddr = VAW'(((32'(i_item.cell_z) * SY + 32'(i_item.cell_y)) * SX
                      + 32'(i_item.cell_x)) * 4 + 32'(i_item.component));
    assign w_cwaddr = CAW'({cell_of(i_item.cell_x, i_item.cell_y, i_item.cell_z),
                      i_item.component, i_item.coef_index});

    assign w_t = term_of(r_row, r_term);
    always_comb begin
        w_nx = r_item.cell_x;
        w_ny = r_item.cell_y;
        w_nz = r_item.cell_z;
        unique case (w_t.nb)
            NB_ZM:   w_nz = r_item.cell_z - 5'd1;
            NB_ZP:   w_nz = r_item.cell_z + 5'd1;
            NB_YM:   w_ny = r_item.cell_y - 5'd1;
            NB_YP:   w_ny = r_item.cell_y + 5'd1;
            NB_XM:   w_nx = r_item.cell_x - 5'd1;
            NB_XP:   w_nx = r_item.cell_x + 5'd1;
            default: ;
        endcase
    end
    assign w_cell   = cell_of(r_item.cell_x, r_item.cell_y, r_item.cell_z);
    assign w_craddr = CAW'({w_cell, r_row, w_t.slot});
    assign w_vraddr = VAW'(((32'(w_nz) * SY + 32'(w_ny)) * SX + 32'(w_nx)) * 4
                      + 32'(w_t.cmp));

    // Memories: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (w_take && i_item.req_type == REQ_VEC && w_vok) begin
            r_vmem[w_vwaddr] <= i_item.value;
        end
        r_vq <= r_vmem[w_vraddr];
    end
    always_ff @(posedge i_clk) begin
        if (w_take && i_item.req_type == REQ_COEF && w_cok) begin
            r_cmem[w_cwaddr] <= i_item.value;
        end
        r_cq <= r_cmem[w_craddr];
    end

    assign w_clear = r_state == S_IDLE || r_state == S_FIN;
    assign w_acc   = r_rdv;

    bsm3_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .i_valid (w_acc),
        .i_a     (r_cq),
        .i_b     (r_vq),
        .o_round (w_mres),
        .o_sat   (w_msat),
        .o_busy  (w_mbusy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rdv   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_rdv  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_item <= i_item;
                        r_row  <= 2'd0;
                        r_term <= 4'd0;
                        r_sat  <= 1'b0;
                        if (i_item.req_type == REQ_CALC && w_inner) begin
                            r_out   <= '0;
                            r_state <= S_RUN;
                        end else begin
                            r_out <= '{result_er: '0, result_f1: '0, result_f2: '0,
                                       result_f3: '0,
                                       status: ((i_item.req_type == REQ_VEC && w_vok)
                                           || (i_item.req_type == REQ_COEF && w_cok))
                                           ? ST_OK : ST_BAD};
                            r_state <= S_OUT;
                        end
                    end
                end
                S_RUN: begin
                    r_rdv <= 1'b1;
                    if (r_term == ((r_row == 2'd0) ? 4'd15 : 4'd13)) begin
                        r_state <= S_DRN;
                        r_drn   <= 3'd0;
                    end else begin
                        r_term <= r_term + 4'd1;
                    end
                end
                S_DRN: begin
                    // Memory read, product register and accumulate drain.
                    r_drn <= r_drn + 3'd1;
                    if (r_drn == 3'd2) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_res[r_row] <= w_mres;
                    r_sat <= r_sat | w_msat;
                    r_term <= 4'd0;
                    if (r_row == 2'd3) begin
                        r_state <= S_OUT;
                        r_out <= '{result_er: r_res[0], result_f1: r_res[1],
                                   result_f2: r_res[2], result_f3: w_mres,
                                   status: (r_sat | w_msat) ? ST_SAT : ST_OK};
                    end else begin
                        r_row   <= r_row + 2'd1;
                        r_state <= S_RUN;
                    end
                end
                S_OUT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = r_state != S_IDLE || r_done;
    assign o_done   = r_done;
    assign o_result = r_out;

    // r_last is a stage marker for checks only.
    always_ff @(posedge i_clk) begin
        r_last <= r_state == S_FIN && r_row == 2'd3;
    end

    a_one_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held two cycles");
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last |-> r_state == S_OUT) else $error("compute end lost");
    a_mac_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |-> !w_mbusy) else $error("row closed with term in flight");
endmodule
`default_nettype wire

FILE: hdl/bsm3_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsm3_mac: row accumulator
// Registers one 32x32 product a cycle, sums it exactly and rounds and
// saturates the row sum when asked.
// ----------------------------------------------------------------------------
module bsm3_mac #(
    parameter int FRAC_BITS = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_clear,
    input  wire               i_valid,
    input  wire signed [31:0] i_a,
    input  wire signed [31:0] i_b,
    output logic signed [31:0] o_round,
    output logic              o_sat,
    output logic              o_busy
);
    import bsm3_pkg::*;

    localparam int ACC_W = 69;

    logic signed [63:0]      r_prod;
    logic                    r_pv;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] w_rnd;
    logic signed [ACC_W-1:0] w_shift;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_valid;
        end
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_busy  = r_pv;
    assign w_rnd   = r_acc + (ACC_W'(1) <<< (FRAC_BITS - 1));
    assign w_shift = w_rnd >>> FRAC_BITS;

    always_comb begin
        o_sat = 1'b0;
        if (w_shift > ACC_W'(64'sd2147483647)) begin
            o_round = 32'sh7fffffff;
            o_sat   = 1'b1;
        end else if (w_shift < -ACC_W'(64'sd2147483648)) begin
            o_round = 32'sh80000000;
            o_sat   = 1'b1;
        end else begin
            o_round = w_shift[31:0];
        end
    end
endmodule
`default_nettype wire
